// File: sv/sfs_pkg.sv
// Shared types and constants of the sprite frame stepper.
// No dependencies; imported by sfs_cfg, sfs_div and sprite_frame_stepper.
`default_nettype none

package sfs_pkg;

  // Register map, one 32-bit word per register
  typedef enum logic [2:0] {
    REG_SOURCE_X     = 3'd0,
    REG_SOURCE_Y     = 3'd1,
    REG_FRAME_WIDTH  = 3'd2,
    REG_FRAME_HEIGHT = 3'd3,
    REG_FRAME_COUNT  = 3'd4,
    REG_FRAME_DELAY  = 3'd5,
    REG_SHEET_WIDTH  = 3'd6,
    REG_SHEET_HEIGHT = 3'd7
  } reg_idx_e;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_JUMP = 1'b1
  } op_e;

  localparam int ADDR_W    = 5;
  localparam int SIZE_W    = 13;     // pixel sizes and divisors
  localparam int UV_QBITS  = 17;     // quotient bits of one UV bound
  localparam logic [16:0] TICK_STEP = 17'd16;
  localparam logic [15:0] DELAY_MIN = 16'd16;
  localparam logic [16:0] UV_SAT    = 17'h1FFFF;

  typedef struct packed {
    logic [11:0] source_x;
    logic [11:0] source_y;
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [8:0]  frame_count;
    logic [15:0] frame_delay;
    logic [12:0] sheet_width;
    logic [12:0] sheet_height;
  } cfg_t;

  // Write event toward the sequencer, with the frame count as it will be
  typedef struct packed {
    logic       wr;
    logic [8:0] count_nxt;
  } cfg_wr_t;

endpackage

`default_nettype wire

// File: sv/sfs_cfg.sv
// APB register file of the sprite frame stepper.
// Depends on sfs_pkg.
`default_nettype none

module sfs_cfg #(
  parameter int COORD_BITS = 12
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire [sfs_pkg::ADDR_W-1:0]  paddr,
  input  wire [31:0]                 pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output sfs_pkg::cfg_t              cfg_o,
  output sfs_pkg::cfg_wr_t           wr_o
);
  import sfs_pkg::*;

  localparam logic [15:0] CMASK16 = 16'((17'(1) << COORD_BITS) - 17'(1));

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[4:2]);
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_SOURCE_X:     cfg_d.source_x     = pwdata[11:0] & CMASK16[11:0];
        REG_SOURCE_Y:     cfg_d.source_y     = pwdata[11:0] & CMASK16[11:0];
        REG_FRAME_WIDTH:  cfg_d.frame_width  = pwdata[12:0];
        REG_FRAME_HEIGHT: cfg_d.frame_height = pwdata[12:0];
        REG_FRAME_COUNT:  cfg_d.frame_count  = pwdata[8:0];
        REG_FRAME_DELAY:  cfg_d.frame_delay  = pwdata[15:0];
        REG_SHEET_WIDTH:  cfg_d.sheet_width  = pwdata[12:0];
        REG_SHEET_HEIGHT: cfg_d.sheet_height = pwdata[12:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_x     <= 12'd0;
      cfg_q.source_y     <= 12'd0;
      cfg_q.frame_width  <= 13'd16;
      cfg_q.frame_height <= 13'd16;
      cfg_q.frame_count  <= 9'd1;
      cfg_q.frame_delay  <= 16'd16;
      cfg_q.sheet_width  <= 13'd1;
      cfg_q.sheet_height <= 13'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      REG_SOURCE_X:     prdata = 32'(cfg_q.source_x);
      REG_SOURCE_Y:     prdata = 32'(cfg_q.source_y);
      REG_FRAME_WIDTH:  prdata = 32'(cfg_q.frame_width);
      REG_FRAME_HEIGHT: prdata = 32'(cfg_q.frame_height);
      REG_FRAME_COUNT:  prdata = 32'(cfg_q.frame_count);
      REG_FRAME_DELAY:  prdata = 32'(cfg_q.frame_delay);
      REG_SHEET_WIDTH:  prdata = 32'(cfg_q.sheet_width);
      REG_SHEET_HEIGHT: prdata = 32'(cfg_q.sheet_height);
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg_o        = cfg_q;
  assign wr_o.wr        = wr_en;
  assign wr_o.count_nxt = cfg_d.frame_count;

endmodule

`default_nettype wire

// File: sv/sfs_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on sfs_pkg for the divisor width.
`default_nettype none

module sfs_div #(
  parameter int NUM_W  = 22,
  parameter int STEP_W = 5
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  input  wire [NUM_W-1:0]            num_i,   // dividend bits, MSB first
  input  wire [sfs_pkg::SIZE_W-1:0]  rem_i,   // initial partial remainder
  input  wire [sfs_pkg::SIZE_W-1:0]  den_i,
  input  wire [STEP_W-1:0]           steps_i,
  output logic [NUM_W-1:0]           quo_o,
  output logic [sfs_pkg::SIZE_W-1:0] rem_o,
  output logic                       done_o
);
  import sfs_pkg::*;

  logic [STEP_W-1:0] cnt_q;
  logic              done_q;
  logic [SIZE_W-1:0] rem_q;
  logic [SIZE_W-1:0] den_q;
  logic [NUM_W-1:0]  sh_q;
  logic [NUM_W-1:0]  quo_q;
  logic [SIZE_W:0]   trial;
  logic [SIZE_W:0]   diff;
  logic              ge;

  assign trial = {rem_q, sh_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= steps_i;
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - STEP_W'(1);
      done_q <= (cnt_q == STEP_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      den_q <= den_i;
      sh_q  <= num_i;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
      sh_q  <= sh_q << 1;
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// File: sv/sprite_frame_stepper.sv
// Top level of the sprite frame stepper: frame sequencer and UV normalization.
// Depends on sfs_pkg, sfs_cfg and sfs_div.
`default_nettype none

// Sprite-sheet animation stepper. Each input transaction is either a tick
// (adds 16 to the delay accumulator unless held or the animation has a single
// frame; reaching frame_delay advances the frame, wrapping at frame_count) or a
// jump to frame_index (ignored when not below frame_count). Every transaction
// yields one output transaction with the resulting frame index, an advanced
// flag and the frame's texture rectangle as unsigned 1.16 U/V bounds that
// saturate at 131071; flip_x/flip_y swap the bounds. Frames wrap into further
// sheet rows at sheet_width. All division runs through one bit-serial
// restoring divider: first the row split of the X_W-bit x position (X_W =
// 14 + frame position bits, 22 at default parameters), then each of the
// four bounds in turn; in_stall_o stays high from the accepted transaction
// until its result is loaded into the output register. A finished result
// waits in the output register, and a new input transaction is taken while it
// waits. Configuration goes through an APB port, one 32-bit register per word;
// any write clears the delay accumulator and pulls the frame back to zero when
// it no longer fits the frame count. Write registers only while idle.
module sprite_frame_stepper #(
  parameter int MAX_FRAMES       = 256,
  parameter int COORD_BITS       = 12,
  parameter int UV_FRACTION_BITS = 16
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // APB configuration
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire [sfs_pkg::ADDR_W-1:0]  paddr,
  input  wire [31:0]                 pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // input transactions
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  wire                        operation_i,
  input  wire [7:0]                  frame_index_i,
  input  wire                        hold_i,
  input  wire                        flip_x_i,
  input  wire                        flip_y_i,
  // output transactions
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output logic [7:0]                 current_index_o,
  output logic                       advanced_o,
  output logic [16:0]                u_min_o,
  output logic [16:0]                u_max_o,
  output logic [16:0]                v_min_o,
  output logic [16:0]                v_max_o
);
  import sfs_pkg::*;

  // Frame count register is 9 bits, so the usable count never exceeds 511
  localparam int CNT_MAX = (MAX_FRAMES < 511) ? MAX_FRAMES : 511;
  localparam int POS_W   = $clog2(CNT_MAX);
  localparam int X_W     = SIZE_W + POS_W + 1;   // source_x + width * frame
  localparam int P_W     = SIZE_W + X_W + 1;     // y + frame_height
  localparam int N_W     = P_W + UV_FRACTION_BITS;
  localparam int HI_W    = N_W - UV_QBITS;
  localparam int DIV_W   = (X_W > UV_QBITS) ? X_W : UV_QBITS;
  localparam int STEP_W  = $clog2(DIV_W + 1);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_MULX    = 10'b00_0000_0010,
    ST_ROW_GO  = 10'b00_0000_0100,
    ST_ROW_WT  = 10'b00_0000_1000,
    ST_MULY    = 10'b00_0001_0000,
    ST_ENDS    = 10'b00_0010_0000,
    ST_UV_GO   = 10'b00_0100_0000,
    ST_UV_WT   = 10'b00_1000_0000,
    ST_DONE    = 10'b01_0000_0000,
    ST_SPARE   = 10'b10_0000_0000
  } state_e;

  function automatic logic [9:0] eff_count(input logic [8:0] raw);
    logic [9:0] c;
    c = {1'b0, raw};
    if (raw == 9'd0) begin
      c = 10'd1;
    end else if (c > 10'(CNT_MAX)) begin
      c = 10'(CNT_MAX);
    end
    return c;
  endfunction

  cfg_t    cfg;
  cfg_wr_t cfg_wr;

  sfs_cfg #(
    .COORD_BITS (COORD_BITS)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .wr_o    (cfg_wr)
  );

  // Effective configuration
  logic [9:0]        cnt_eff, cnt_nxt_eff;
  logic [15:0]       delay_eff;
  logic [SIZE_W-1:0] w_eff, h_eff;

  assign cnt_eff     = eff_count(cfg.frame_count);
  assign cnt_nxt_eff = eff_count(cfg_wr.count_nxt);
  assign delay_eff   = (cfg.frame_delay < DELAY_MIN) ? DELAY_MIN : cfg.frame_delay;
  assign w_eff       = (cfg.sheet_width  == '0) ? SIZE_W'(1) : cfg.sheet_width;
  assign h_eff       = (cfg.sheet_height == '0) ? SIZE_W'(1) : cfg.sheet_height;

  // Control state
  state_e            state_q, state_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [16:0]       acc_q, acc_d;
  logic [1:0]        k_q, k_d;
  logic              out_valid_q, out_valid_d;

  // Datapath registers
  logic              flip_x_q, flip_y_q, adv_q, sat_q;
  logic [X_W-1:0]    x_q;
  logic [X_W-1:0]    row_q;
  logic [P_W-1:0]    px_q [4];   // x, x + width, y, y + height
  logic [16:0]       uv_q [4];   // matching bounds
  logic [7:0]        idx_out_q;
  logic [16:0]       umin_q, umax_q, vmin_q, vmax_q;

  logic              in_acc, out_fire, out_load;
  logic [16:0]       acc_sum;
  logic [9:0]        pos_inc;
  logic [15:0]       pos_ext;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_fire = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == ST_DONE) && out_fire;
  assign acc_sum  = acc_q + TICK_STEP;
  assign pos_inc  = 10'(pos_q) + 10'd1;
  assign pos_ext  = 16'(pos_q);

  // Frame position and delay accumulator
  always_comb begin
    pos_d = pos_q;
    acc_d = acc_q;
    if (cfg_wr.wr) begin
      acc_d = '0;
      if (10'(pos_q) >= cnt_nxt_eff) begin
        pos_d = '0;
      end
    end else if (in_acc) begin
      if (op_e'(operation_i) == OP_JUMP) begin
        if (10'(frame_index_i) < cnt_eff) begin
          pos_d = POS_W'(frame_index_i);
        end
      end else if ((cnt_eff > 10'd1) && !hold_i) begin
        if (acc_sum >= {1'b0, delay_eff}) begin
          acc_d = acc_sum - {1'b0, delay_eff};
          pos_d = (pos_inc >= cnt_eff) ? '0 : POS_W'(pos_inc);
        end else begin
          acc_d = acc_sum;
        end
      end
    end
  end

  // Shared divider and its operand selection
  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_num, div_quo;
  logic [SIZE_W-1:0] div_rem_in, div_den, div_rem;
  logic [STEP_W-1:0] div_steps;
  logic [P_W-1:0]    pix;
  logic [N_W-1:0]    num_wide;
  logic [HI_W-1:0]   hi;
  logic [SIZE_W-1:0] den_uv;
  logic              uv_sat;

  assign pix      = px_q[k_q];
  assign num_wide = N_W'(pix) << UV_FRACTION_BITS;
  assign hi       = num_wide[N_W-1:UV_QBITS];
  assign den_uv   = k_q[1] ? h_eff : w_eff;
  // Quotient reaches 2^17 exactly when the upper dividend part is not below d
  assign uv_sat   = hi >= HI_W'(den_uv);

  assign div_start = (state_q == ST_ROW_GO) || (state_q == ST_UV_GO);

  always_comb begin
    if (state_q == ST_UV_GO) begin
      div_num    = DIV_W'(num_wide[UV_QBITS-1:0]) << (DIV_W - UV_QBITS);
      div_rem_in = uv_sat ? '0 : hi[SIZE_W-1:0];
      div_den    = den_uv;
      div_steps  = STEP_W'(UV_QBITS);
    end else begin
      div_num    = DIV_W'(x_q) << (DIV_W - X_W);
      div_rem_in = '0;
      div_den    = w_eff;
      div_steps  = STEP_W'(X_W);
    end
  end

  sfs_div #(
    .NUM_W  (DIV_W),
    .STEP_W (STEP_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .rem_i   (div_rem_in),
    .den_i   (div_den),
    .steps_i (div_steps),
    .quo_o   (div_quo),
    .rem_o   (div_rem),
    .done_o  (div_done)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_MULX;
        end
      end
      ST_MULX: begin
        k_d     = '0;
        state_d = ST_ROW_GO;
      end
      ST_ROW_GO: state_d = ST_ROW_WT;
      ST_ROW_WT: begin
        if (div_done) begin
          state_d = ST_MULY;
        end
      end
      ST_MULY:   state_d = ST_ENDS;
      ST_ENDS:   state_d = ST_UV_GO;
      ST_UV_GO:  state_d = ST_UV_WT;
      ST_UV_WT: begin
        if (div_done) begin
          k_d     = k_q + 2'd1;
          state_d = (k_q == 2'd3) ? ST_DONE : ST_UV_GO;
        end
      end
      ST_DONE: begin
        if (out_fire) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      acc_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      acc_q       <= acc_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Geometry. Row zero needs no special case: there x mod w is x itself and
  // source_y + height * 0 is source_y.
  logic [SIZE_W+POS_W-1:0] prod_x;
  logic [SIZE_W+X_W-1:0]   prod_y;

  assign prod_x = cfg.frame_width * pos_q;
  assign prod_y = cfg.frame_height * row_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      flip_x_q <= flip_x_i;
      flip_y_q <= flip_y_i;
      adv_q    <= (pos_d != pos_q);
    end
    if (state_q == ST_MULX) begin
      x_q <= X_W'(cfg.source_x) + X_W'(prod_x);
    end
    if ((state_q == ST_ROW_WT) && div_done) begin
      row_q    <= div_quo[X_W-1:0];
      px_q[0]  <= P_W'(div_rem);
    end
    if (state_q == ST_MULY) begin
      px_q[2] <= P_W'(cfg.source_y) + P_W'(prod_y);
    end
    if (state_q == ST_ENDS) begin
      px_q[1] <= px_q[0] + P_W'(cfg.frame_width);
      px_q[3] <= px_q[2] + P_W'(cfg.frame_height);
    end
    if (state_q == ST_UV_GO) begin
      sat_q <= uv_sat;
    end
    if ((state_q == ST_UV_WT) && div_done) begin
      uv_q[k_q] <= sat_q ? UV_SAT : div_quo[UV_QBITS-1:0];
    end
    if (out_load) begin
      idx_out_q <= pos_ext[7:0];
      umin_q    <= flip_x_q ? uv_q[1] : uv_q[0];
      umax_q    <= flip_x_q ? uv_q[0] : uv_q[1];
      vmin_q    <= flip_y_q ? uv_q[3] : uv_q[2];
      vmax_q    <= flip_y_q ? uv_q[2] : uv_q[3];
    end
  end

  // advanced travels with the result; capture it at load as well
  logic adv_out_q;
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      adv_out_q <= adv_q;
    end
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign current_index_o = idx_out_q;
  assign advanced_o      = adv_out_q;
  assign u_min_o         = umin_q;
  assign u_max_o         = umax_q;
  assign v_min_o         = vmin_q;
  assign v_max_o         = vmax_q;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    10'(pos_q) < cnt_eff)
    else $error("frame position not below effective frame count");

  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q < {1'b0, delay_eff})
    else $error("delay accumulator reached effective delay");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_MULX))
    else $error("accepted transaction did not start the sequence");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> ((state_q == ST_ROW_WT) || (state_q == ST_UV_WT)))
    else $error("divider finished outside a wait state");
`endif

endmodule

`default_nettype wire
